@@ sv/utf8d_pkg.sv @@
// Shared types and constants of the UTF-8 byte stream decoder.
package utf8d_pkg;

	localparam int UTF8D_QUEUE_DEPTH = 2;

	localparam int POINT_W   = 21;
	localparam int COUNT_W   = 3;
	localparam int PAYLOAD_W = 7;

	typedef enum logic [2:0] {
		CL_ASCII = 3'd0,
		CL_CONT  = 3'd1,
		CL_LEAD2 = 3'd2,
		CL_LEAD3 = 3'd3,
		CL_LEAD4 = 3'd4,
		CL_BAD   = 3'd5,
		CL_EOI   = 3'd6
	} byte_class_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_END = 2'd1,
		ST_BAD = 2'd2
	} status_t;

	typedef struct packed {
		byte_class_t           cls;
		logic [PAYLOAD_W-1:0]  payload;
	} item_t;

endpackage

@@ sv/utf8d_front.sv @@
// Input stage that accepts stream bytes and classifies them for the decoder.
module utf8d_front
	import utf8d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	output logic        push,
	output item_t       push_item,
	input  logic        full
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_c;

	always_comb begin
		item_c.cls = CL_BAD;
		item_c.payload = '0;
		if (s_axis_tuser) begin
			item_c.cls = CL_EOI;
		end else begin
			case (s_axis_tdata) inside
				[8'h00:8'h7F]: begin
					item_c.cls = CL_ASCII;
					item_c.payload = s_axis_tdata[6:0];
				end
				[8'h80:8'hBF]: begin
					item_c.cls = CL_CONT;
					item_c.payload = {1'b0, s_axis_tdata[5:0]};
				end
				[8'hC2:8'hDF]: begin
					item_c.cls = CL_LEAD2;
					item_c.payload = {2'b0, s_axis_tdata[4:0]};
				end
				[8'hE0:8'hEF]: begin
					item_c.cls = CL_LEAD3;
					item_c.payload = {3'b0, s_axis_tdata[3:0]};
				end
				[8'hF0:8'hF4]: begin
					item_c.cls = CL_LEAD4;
					item_c.payload = {4'b0, s_axis_tdata[2:0]};
				end
				default: begin
					item_c.cls = CL_BAD;
				end
			endcase
		end
	end

	assign push          = valid_s1 && !full;
	assign push_item     = item_s1;
	assign s_axis_tready = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_c;
		end
	end

endmodule

@@ sv/utf8d_queue.sv @@
// Short queue of classified bytes between the front and back stages.
module utf8d_queue
	import utf8d_pkg::*;
#(
	parameter int DEPTH = UTF8D_QUEUE_DEPTH
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Queue count exceeds its depth.");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Queue count did not grow on a lone write.");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("Queue read while empty.");

endmodule

@@ sv/utf8d_back.sv @@
// Sequence decoder that gathers payload bits and registers the result beats.
module utf8d_back
	import utf8d_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      not_empty,
	input  item_t                     pop_item,
	output logic                      pop,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [23:0]               m_axis_tdata,
	output logic [1:0]                m_axis_tuser
);

	logic [1:0]          bytes_left_q;
	logic [POINT_W-1:0]  partial_point_q;
	logic [COUNT_W-1:0]  bytes_taken_q;

	logic                m_valid_q;
	logic [POINT_W-1:0]  point_q;
	logic [COUNT_W-1:0]  count_q;
	status_t             status_q;

	logic                out_free;
	logic                res_c;
	logic [POINT_W-1:0]  res_point_c;
	logic [COUNT_W-1:0]  res_count_c;
	status_t             res_status_c;
	logic [1:0]          left_d;
	logic [POINT_W-1:0]  partial_d;
	logic [COUNT_W-1:0]  taken_d;
	logic [POINT_W-1:0]  shifted_c;

	assign out_free = !m_valid_q || m_axis_tready;
	assign pop      = not_empty && out_free;

	assign shifted_c = {partial_point_q[POINT_W-7:0], pop_item.payload[5:0]};

	always_comb begin
		res_c        = 1'b0;
		res_point_c  = '0;
		res_count_c  = '0;
		res_status_c = ST_BAD;
		left_d       = bytes_left_q;
		partial_d    = partial_point_q;
		taken_d      = bytes_taken_q;
		if (bytes_left_q == 2'd0) begin
			case (pop_item.cls)
				CL_EOI: begin
					res_c        = 1'b1;
					res_status_c = ST_END;
				end
				CL_ASCII: begin
					res_c        = 1'b1;
					res_status_c = ST_OK;
					res_point_c  = POINT_W'(pop_item.payload);
					res_count_c  = COUNT_W'(1);
				end
				CL_LEAD2: begin
					left_d    = 2'd1;
					partial_d = POINT_W'(pop_item.payload);
					taken_d   = COUNT_W'(1);
				end
				CL_LEAD3: begin
					left_d    = 2'd2;
					partial_d = POINT_W'(pop_item.payload);
					taken_d   = COUNT_W'(1);
				end
				CL_LEAD4: begin
					left_d    = 2'd3;
					partial_d = POINT_W'(pop_item.payload);
					taken_d   = COUNT_W'(1);
				end
				default: begin
					res_c        = 1'b1;
					res_status_c = ST_BAD;
				end
			endcase
		end else if (pop_item.cls != CL_CONT) begin
			res_c        = 1'b1;
			res_status_c = ST_BAD;
			left_d       = '0;
			partial_d    = '0;
			taken_d      = '0;
		end else if (bytes_left_q == 2'd1) begin
			res_c        = 1'b1;
			res_status_c = ST_OK;
			res_point_c  = shifted_c;
			res_count_c  = bytes_taken_q + 1'b1;
			left_d       = '0;
			partial_d    = '0;
			taken_d      = '0;
		end else begin
			left_d    = bytes_left_q - 1'b1;
			partial_d = shifted_c;
			taken_d   = bytes_taken_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q    <= '0;
			partial_point_q <= '0;
			bytes_taken_q   <= '0;
			m_valid_q       <= 1'b0;
		end else begin
			if (pop) begin
				bytes_left_q    <= left_d;
				partial_point_q <= partial_d;
				bytes_taken_q   <= taken_d;
			end
			if (out_free) begin
				m_valid_q <= pop && res_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_c && out_free) begin
			point_q  <= res_point_c;
			count_q  <= res_count_c;
			status_q <= res_status_c;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {count_q, point_q};
	assign m_axis_tuser  = status_q;

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_left_q == 2'd0) |-> (bytes_taken_q == '0 && partial_point_q == '0))
		else $error("Idle decoder holds leftover sequence state.");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_left_q != 2'd0) |->
		((bytes_taken_q != '0) && ({1'b0, bytes_taken_q} + 4'(bytes_left_q) <= 4'd4)))
		else $error("Sequence length bookkeeping out of range.");

	a_beat_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> ((status_q == ST_OK && count_q != '0) ||
		(status_q != ST_OK && count_q == '0 && point_q == '0)))
		else $error("Result beat fields disagree with its status.");

	a_open_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && bytes_left_q == 2'd0 && left_d != 2'd0) |-> !res_c)
		else $error("Opening a sequence produced a result.");

endmodule

@@ sv/utf8_byte_stream_decoder.sv @@
// Top level of the UTF-8 byte stream decoder.
// Takes one byte or end-of-input beat per clock while s_axis_tready is high and
// returns one beat for each finished code point, bad sequence or end of input;
// lead and middle bytes of a sequence return nothing. A byte beat is registered
// and classified, passes a QUEUE_DEPTH-entry queue and is decoded into the output
// register. The decoder step retires one queued byte per clock, which sets the
// sustained rate at one input beat per cycle whenever the output side keeps up.
module utf8_byte_stream_decoder
	import utf8d_pkg::*;
#(
	parameter int QUEUE_DEPTH = UTF8D_QUEUE_DEPTH
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // decoded_point[20:0], byte_count[23:21]
	output logic [1:0]  m_axis_tuser    // status
);

	logic  push;
	item_t push_item;
	logic  full;
	logic  pop;
	logic  not_empty;
	item_t pop_item;

	utf8d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_item     (push_item),
		.full          (full)
	);

	utf8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_item  (pop_item)
	);

	utf8d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.not_empty     (not_empty),
		.pop_item      (pop_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ sim/tb_utf8_byte_stream_decoder.sv @@
// Self-checking testbench for the UTF-8 byte stream decoder with a code point scoreboard.
module tb_utf8_byte_stream_decoder;
	import utf8d_pkg::*;

	localparam int RANDOM_BYTES = 1500;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [POINT_W-1:0] point;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} point_beat_t;

	class code_point_tracker;
		point_beat_t        due[$];
		int                 mismatches;
		logic [1:0]         left;
		logic [POINT_W-1:0] part;
		logic [COUNT_W-1:0] taken;

		function new();
			left = '0;
			part = '0;
			taken = '0;
			mismatches = 0;
		endfunction

		function void queue_beat(logic [POINT_W-1:0] point, status_t status,
				logic [COUNT_W-1:0] count);
			point_beat_t beat;
			beat.point = point;
			beat.status = status;
			beat.count = count;
			due.push_back(beat);
		endfunction

		function void note_byte(logic [7:0] b, logic eoi);
			if (left == 2'd0) begin
				if (eoi) begin
					queue_beat('0, ST_END, '0);
				end else if (!b[7]) begin
					queue_beat({{(POINT_W-8){1'b0}}, b}, ST_OK, 3'd1);
				end else if (b < 8'hC2 || b > 8'hF4) begin
					queue_beat('0, ST_BAD, '0);
				end else begin
					if (b[7:3] == 5'b11110) begin
						left = 2'd3;
						part = {{(POINT_W-3){1'b0}}, b[2:0]};
					end else if (b[7:4] == 4'hE) begin
						left = 2'd2;
						part = {{(POINT_W-4){1'b0}}, b[3:0]};
					end else begin
						left = 2'd1;
						part = {{(POINT_W-5){1'b0}}, b[4:0]};
					end
					taken = 3'd1;
				end
			end else if (eoi || b[7:6] != 2'b10) begin
				left = '0;
				part = '0;
				taken = '0;
				queue_beat('0, ST_BAD, '0);
			end else begin
				part = {part[POINT_W-7:0], b[5:0]};
				taken = taken + 3'd1;
				left = left - 2'd1;
				if (left == 2'd0) begin
					queue_beat(part, ST_OK, taken);
					part = '0;
					taken = '0;
				end
			end
		endfunction

		function void check_point(logic [POINT_W-1:0] point, logic [COUNT_W-1:0] count,
				logic [1:0] status);
			point_beat_t want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: point %h count %0d status %0d",
						point, count, status);
			end else begin
				want = due.pop_front();
				if (want.point !== point || want.count !== count || want.status !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected point %h count %0d status %0d, got point %h count %0d status %0d",
							want.point, want.count, want.status, point, count, status);
				end
			end
		endfunction

		function bit waiting();
			return due.size() != 0;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	code_point_tracker board = new();
	int burst_left = 0;
	int bytes_sent = 0;
	int cycles = 0;

	utf8_byte_stream_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// The receiver's stall behavior is chosen by bits [9:8] of the cycle counter.
	always @(posedge clk) begin
		case (cycles[9:8])
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= ($urandom_range(0, 9) < 7);
			2'd2: m_axis_tready <= (cycles[2:0] != 3'd0);
			default: m_axis_tready <= (cycles[4:0] < 5'd5);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_point(m_axis_tdata[POINT_W-1:0], m_axis_tdata[23:21], m_axis_tuser);
	end

	task automatic send_byte(input logic [7:0] b, input logic eoi);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= eoi;
		do @(posedge clk); while (!s_axis_tready);
		board.note_byte(b, eoi);
		bytes_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.waiting());
	endtask

	function automatic logic [7:0] lead_byte(int len);
		case (len)
			2: return 8'($urandom_range(8'hC2, 8'hDF));
			3: return 8'($urandom_range(8'hE0, 8'hEF));
			default: return 8'($urandom_range(8'hF0, 8'hF4));
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	task automatic send_sequence();
		int kind;
		int len;
		int b;
		kind = $urandom_range(0, 99);
		len = $urandom_range(2, 4);
		if (kind < 20) begin
			send_byte(8'($urandom_range(0, 127)), 1'b0);
		end else if (kind < 80) begin
			send_byte(lead_byte(len), 1'b0);
			repeat (len - 1) send_byte(cont_byte(), 1'b0);
		end else if (kind < 88) begin
			// A sequence cut short by end of input or a byte that is not a continuation.
			send_byte(lead_byte(len), 1'b0);
			repeat ($urandom_range(0, len - 2)) send_byte(cont_byte(), 1'b0);
			if ($urandom_range(0, 2) == 0) begin
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				b = $urandom_range(0, 191);
				if (b >= 128)
					b += 64;
				send_byte(8'(b), 1'b0);
			end
		end else if (kind < 94) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	initial begin
		logic [8:0] directed[$];
		int next_drain;
		directed = '{9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0E0, 9'h080, 9'h080,
			9'h0EF, 9'h0BF, 9'h0BF, 9'h0F0, 9'h090, 9'h080, 9'h080,
			9'h0F4, 9'h0BF, 9'h0BF, 9'h0BF, 9'h080, 9'h0C0, 9'h0F5, 9'h0FF,
			9'h1A5, 9'h0C3, 9'h100, 9'h0E2, 9'h041};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		foreach (directed[i])
			send_byte(directed[i][7:0], directed[i][8]);
		drain();

		next_drain = bytes_sent + 500;
		while (bytes_sent < RANDOM_BYTES + directed.size()) begin
			send_sequence();
			if (bytes_sent >= next_drain) begin
				drain();
				next_drain += 500;
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && !board.waiting())
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ sim.f @@
sv/utf8d_pkg.sv
sv/utf8d_front.sv
sv/utf8d_queue.sv
sv/utf8d_back.sv
sv/utf8_byte_stream_decoder.sv
sim/tb_utf8_byte_stream_decoder.sv
